// ----- design/dad_pkg.sv -----
// shared types and constants for the duplicate address detection table
// no dependencies
package dad_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PROBE_CAP       = 16;

    localparam logic [31:0] RETRANS_RESET    = 32'd1000;
    localparam logic [15:0] PORT_LIMIT_RESET = 16'd64;
    localparam logic [4:0]  MAX_PROBES_RESET = 5'd16;

    localparam logic [1:0] CFG_RETRANS    = 2'd0;
    localparam logic [1:0] CFG_PORT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MAX_PROBES = 2'd2;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_TENT = 2'd1;
    localparam logic [1:0] PH_PREF = 2'd2;
    localparam logic [1:0] PH_DUP  = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_REM_IF   = 3'd2,
        OP_REM_PORT = 3'd3,
        OP_CONFLICT = 3'd4,
        OP_QUERY    = 3'd5,
        OP_POLL     = 3'd6,
        OP_BAD      = 3'd7
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        reject;
        logic [63:0] ifc;
        logic [15:0] port;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  lim;
        logic [31:0] delay;
        logic [47:0] now;
    } qitem_t;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [1:0]  dad_state;
        logic [7:0]  probes_done;
        logic [63:0] ifc;
        logic [15:0] port;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [4:0]  probe_count;
        logic [47:0] earliest;
        logic        dl_valid;
        logic        last;
    } rsp_t;

endpackage

// ----- design/dad_if.sv -----
// channel interfaces for requests, results and register writes
// no dependencies
interface dad_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] ifc_id;
    logic [15:0] port_number;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  probe_limit;
    logic [31:0] start_delay;
    logic [47:0] now_time;
    modport source (output valid, req_type, ifc_id, port_number, address_high,
                    address_low, probe_limit, start_delay, now_time, input ready);
    modport sink (input valid, req_type, ifc_id, port_number, address_high,
                  address_low, probe_limit, start_delay, now_time, output ready);
endinterface

interface dad_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        ok;
    logic [1:0]  dad_state;
    logic [7:0]  probes_done;
    logic [63:0] out_ifc_id;
    logic [15:0] out_port;
    logic [63:0] out_address_high;
    logic [63:0] out_address_low;
    logic [4:0]  probe_count;
    logic [47:0] earliest_deadline;
    logic        deadline_valid;
    logic        last;
    modport source (output valid, kind, ok, dad_state, probes_done, out_ifc_id,
                    out_port, out_address_high, out_address_low, probe_count,
                    earliest_deadline, deadline_valid, last, input ready);
    modport sink (input valid, kind, ok, dad_state, probes_done, out_ifc_id,
                  out_port, out_address_high, out_address_low, probe_count,
                  earliest_deadline, deadline_valid, last, output ready);
endinterface

interface dad_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/dad_front.sv -----
// request intake: decodes and screens each word, then queues it for the table engine
// depends on dad_pkg and dad_if
module dad_front
    import dad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    dad_req_if.sink      req,
    input  logic [15:0]  port_limit,
    output logic         q_valid,
    output qitem_t       q_item,
    input  logic         q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    qitem_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    qitem_t          item;
    logic            push;

    always_comb
    begin
        item.op      = op_t'(req.req_type);
        item.ifc     = req.ifc_id;
        item.port    = req.port_number;
        item.addr_hi = req.address_high;
        item.addr_lo = req.address_low;
        item.lim     = req.probe_limit;
        item.delay   = req.start_delay;
        item.now     = req.now_time;
        item.reject  = (req.ifc_id == 64'd0) || (req.port_number >= port_limit)
                    || ((req.address_high == 64'd0) && (req.address_low == 64'd0))
                    || (req.address_high[63:56] == 8'hFF);
    end

    assign req.ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- design/dad_back.sv -----
// table engine: entry storage, parallel match, poll scan and deadline sweep
// depends on dad_pkg and dad_if
module dad_back
    import dad_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  qitem_t       q_item,
    output logic         q_pop,
    input  logic [31:0]  retrans,
    input  logic [4:0]   max_probes,
    dad_rsp_if.source    rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TB = TIME_BITS;
    localparam logic [TB-1:0] TMAX = '1;
    localparam logic [63:0] TMAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TB);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MATCH = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MIN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [31:0] b);
        logic [TB+32:0] s;
        s = {33'd0, a} + {{(TB + 1){1'b0}}, b};
        if (s > {33'd0, TMAX})
            return TMAX;
        return s[TB-1:0];
    endfunction

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [63:0]   e_ifc_reg   [TABLE_DEPTH];
    logic [15:0]   e_port_reg  [TABLE_DEPTH];
    logic [63:0]   e_hi_reg    [TABLE_DEPTH];
    logic [63:0]   e_lo_reg    [TABLE_DEPTH];
    logic [1:0]    e_phase_reg [TABLE_DEPTH];
    logic [7:0]    e_lim_reg   [TABLE_DEPTH];
    logic [7:0]    e_sent_reg  [TABLE_DEPTH];
    logic [TB-1:0] e_dl_reg    [TABLE_DEPTH];

    state_t        state_reg, state_next;
    qitem_t        cur_reg, cur_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0]    n_reg, n_next;
    logic [TB-1:0] best_reg, best_next;
    logic          ok_reg, ok_next;
    logic [1:0]    st_reg, st_next;
    logic [7:0]    done_reg, done_next;
    rsp_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [TABLE_DEPTH-1:0] mvec_reg, ifvec_reg, portvec_reg;
    logic [TABLE_DEPTH-1:0] mvec, ifvec, portvec;
    logic [IW-1:0] midx_reg, midx, fidx_reg, fidx;
    logic          free_reg, free_any;

    logic [TB-1:0] now_c;
    logic [63:0]   now64;
    logic [63:0]   best64;
    logic [IW-1:0] sidx;
    logic [4:0]    cap;
    logic          ofree;
    logic          due;
    logic          wr_add, wr_conf, wr_probe, wr_pref;
    logic [TABLE_DEPTH-1:0] clear_vec;

    assign now64 = {16'd0, cur_reg.now};
    assign now_c = (now64 > TMAX64) ? TMAX : now64[TB-1:0];
    assign sidx  = idx_reg[IW-1:0];
    assign cap   = (max_probes > 5'(PROBE_CAP)) ? 5'(PROBE_CAP) : max_probes;
    assign ofree = !out_valid_reg || rsp.ready;
    assign due   = valid_reg[sidx] && (e_phase_reg[sidx] == PH_TENT)
                && (e_dl_reg[sidx] <= now_c);
    assign best64 = 64'(best_reg);

    // parallel match and first free slot
    always_comb
    begin
        midx     = '0;
        fidx     = '0;
        free_any = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            mvec[i]    = valid_reg[i] && (e_ifc_reg[i] == cur_reg.ifc)
                      && (e_hi_reg[i] == cur_reg.addr_hi) && (e_lo_reg[i] == cur_reg.addr_lo);
            ifvec[i]   = valid_reg[i] && (e_ifc_reg[i] == cur_reg.ifc);
            portvec[i] = valid_reg[i] && (e_port_reg[i] == cur_reg.port);
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (mvec[i])
                midx = IW'(i);
            if (!valid_reg[i])
            begin
                fidx     = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        best_next      = best_reg;
        ok_next        = ok_reg;
        st_next        = st_reg;
        done_next      = done_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        q_pop          = 1'b0;
        wr_add         = 1'b0;
        wr_conf        = 1'b0;
        wr_probe       = 1'b0;
        wr_pref        = 1'b0;
        clear_vec      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ok_next    = 1'b0;
                st_next    = PH_NONE;
                done_next  = 8'd0;
                idx_next   = '0;
                n_next     = '0;
                best_next  = TMAX;
                state_next = S_MIN;
                case (cur_reg.op)
                    OP_ADD:
                    begin
                        if (!cur_reg.reject && (mvec_reg != '0))
                            ok_next = 1'b1;
                        else if (!cur_reg.reject && free_reg)
                        begin
                            wr_add  = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        clear_vec = mvec_reg;
                        ok_next   = (mvec_reg != '0);
                    end
                    OP_REM_IF:
                    begin
                        clear_vec = ifvec_reg;
                        ok_next   = (ifvec_reg != '0);
                    end
                    OP_REM_PORT:
                    begin
                        clear_vec = portvec_reg;
                        ok_next   = (portvec_reg != '0);
                    end
                    OP_CONFLICT:
                    begin
                        if ((mvec_reg != '0) && (e_phase_reg[midx_reg] == PH_TENT))
                        begin
                            wr_conf = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (mvec_reg != '0)
                        begin
                            ok_next   = 1'b1;
                            st_next   = e_phase_reg[midx_reg];
                            done_next = e_sent_reg[midx_reg];
                        end
                    end
                    OP_POLL:
                    begin
                        ok_next    = 1'b1;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (idx_reg == CW'(TABLE_DEPTH))
                begin
                    idx_next   = '0;
                    state_next = S_MIN;
                end
                else if (!due)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (e_sent_reg[sidx] >= e_lim_reg[sidx])
                begin
                    wr_pref  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (n_reg >= cap)
                begin
                    idx_next   = '0;
                    state_next = S_MIN;
                end
                else if (ofree)
                begin
                    wr_probe         = 1'b1;
                    out_next         = '0;
                    out_next.kind    = 1'b1;
                    out_next.ok      = 1'b1;
                    out_next.ifc     = e_ifc_reg[sidx];
                    out_next.port    = e_port_reg[sidx];
                    out_next.addr_hi = e_hi_reg[sidx];
                    out_next.addr_lo = e_lo_reg[sidx];
                    out_valid_next   = 1'b1;
                    n_next           = n_reg + 1'b1;
                    idx_next         = idx_reg + 1'b1;
                end
            end
            S_MIN:
            begin
                if (idx_reg == CW'(TABLE_DEPTH))
                    state_next = S_OUT;
                else
                begin
                    if (valid_reg[sidx] && (e_dl_reg[sidx] < best_reg))
                        best_next = e_dl_reg[sidx];
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (ofree)
                begin
                    out_next             = '0;
                    out_next.ok          = ok_reg;
                    out_next.dad_state   = st_reg;
                    out_next.probes_done = done_reg;
                    out_next.probe_count = n_reg;
                    out_next.dl_valid    = (best_reg != TMAX);
                    out_next.earliest    = (best_reg != TMAX) ? best64[47:0] : 48'd0;
                    out_next.last        = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg & ~clear_vec;
        if (wr_add)
            valid_next[fidx_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        best_reg    <= best_next;
        ok_reg      <= ok_next;
        st_reg      <= st_next;
        done_reg    <= done_next;
        out_reg     <= out_next;
        mvec_reg    <= mvec;
        ifvec_reg   <= ifvec;
        portvec_reg <= portvec;
        midx_reg    <= midx;
        fidx_reg    <= fidx;
        free_reg    <= free_any;
        if (wr_add)
        begin
            e_ifc_reg[fidx_reg]   <= cur_reg.ifc;
            e_port_reg[fidx_reg]  <= cur_reg.port;
            e_hi_reg[fidx_reg]    <= cur_reg.addr_hi;
            e_lo_reg[fidx_reg]    <= cur_reg.addr_lo;
            e_lim_reg[fidx_reg]   <= cur_reg.lim;
            e_sent_reg[fidx_reg]  <= 8'd0;
            e_phase_reg[fidx_reg] <= (cur_reg.lim != 8'd0) ? PH_TENT : PH_PREF;
            e_dl_reg[fidx_reg]    <= (cur_reg.lim != 8'd0) ? sat_add(now_c, cur_reg.delay)
                                                           : TMAX;
        end
        if (wr_conf)
        begin
            e_phase_reg[midx_reg] <= PH_DUP;
            e_dl_reg[midx_reg]    <= TMAX;
        end
        if (wr_pref)
        begin
            e_phase_reg[sidx] <= PH_PREF;
            e_dl_reg[sidx]    <= TMAX;
        end
        if (wr_probe)
        begin
            e_sent_reg[sidx] <= e_sent_reg[sidx] + 8'd1;
            e_dl_reg[sidx]   <= sat_add(now_c, retrans);
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.kind              = out_reg.kind;
    assign rsp.ok                = out_reg.ok;
    assign rsp.dad_state         = out_reg.dad_state;
    assign rsp.probes_done       = out_reg.probes_done;
    assign rsp.out_ifc_id        = out_reg.ifc;
    assign rsp.out_port          = out_reg.port;
    assign rsp.out_address_high  = out_reg.addr_hi;
    assign rsp.out_address_low   = out_reg.addr_lo;
    assign rsp.probe_count       = out_reg.probe_count;
    assign rsp.earliest_deadline = out_reg.earliest;
    assign rsp.deadline_valid    = out_reg.dl_valid;
    assign rsp.last              = out_reg.last;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(out_reg))
        else $error("pending result overwritten");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_probe |-> n_reg < cap)
        else $error("probe beyond poll limit");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $onehot0(mvec_reg))
        else $error("duplicate entry in table");

endmodule

// ----- design/dad_address_table.sv -----
// IPv6 duplicate address detection table: holds up to TABLE_DEPTH addresses, each
// tentative, preferred or duplicate, and answers add, remove, conflict, query and poll
// requests. Requests queue two deep in front of the table engine. A request leaves the
// queue, passes a match state and an execute state, sweeps the table for the earliest
// deadline and then sends one status word. A poll adds a scan of the table before the
// sweep, and each probe word waits while the output register is still held by the sink.
// Results leave through an output register, so a stalled sink only holds the engine.
// depends on dad_pkg, dad_if, dad_front and dad_back
module dad_address_table
    import dad_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    dad_req_if.sink    req,
    dad_rsp_if.source  rsp,
    dad_cfg_if.sink    cfg
);

    logic [31:0] retrans_reg;
    logic [15:0] port_limit_reg;
    logic [4:0]  max_probes_reg;
    logic        q_valid;
    logic        q_pop;
    qitem_t      q_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retrans_reg    <= RETRANS_RESET;
            port_limit_reg <= PORT_LIMIT_RESET;
            max_probes_reg <= MAX_PROBES_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RETRANS:    retrans_reg    <= cfg.data;
                CFG_PORT_LIMIT: port_limit_reg <= cfg.data[15:0];
                CFG_MAX_PROBES: max_probes_reg <= cfg.data[4:0];
                default:        retrans_reg    <= retrans_reg;
            endcase
        end
    end

    dad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .port_limit (port_limit_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    dad_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .retrans    (retrans_reg),
        .max_probes (max_probes_reg),
        .rsp        (rsp)
    );

endmodule

// ----- tb/tb_dad_address_table.sv -----
// testbench for the duplicate address detection table: directed and random requests,
// checked word by word against a behavioral table model kept in the testbench
// depends on dad_pkg, dad_if and dad_address_table
`timescale 1ns / 1ps

module tb_dad_address_table;
    import dad_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        op_t         op;
        logic [63:0] ifc;
        logic [15:0] port;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  lim;
        logic [31:0] delay;
        logic [47:0] now;
    } request_t;

    typedef struct {
        bit          valid;
        logic [63:0] ifc;
        logic [15:0] port;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [1:0]  phase;
        logic [7:0]  lim;
        logic [7:0]  sent;
        logic [47:0] deadline;
    } entry_t;

    logic clk;
    logic rst_n;

    dad_req_if req_ch();
    dad_rsp_if rsp_ch();
    dad_cfg_if cfg_ch();

    dad_address_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    entry_t      table_model[DEPTH];
    logic [31:0] retrans_interval;
    logic [15:0] port_limit;
    logic [4:0]  max_probes;

    rsp_t        expected_results[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    logic [47:0] clock_now;
    bit          stall_mode;
    logic [12:0] stall_pattern;

    logic [63:0] ifc_pool[4];
    logic [63:0] hi_pool[4];
    logic [63:0] lo_pool[3];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void queue_word(rsp_t w);
        expected_results = {expected_results, w};
    endfunction

    function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[47:0];
    endfunction

    function automatic int find_entry(logic [63:0] ifc, logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < DEPTH; i++)
            if (table_model[i].valid && table_model[i].ifc == ifc &&
                table_model[i].hi == hi && table_model[i].lo == lo)
                return i;
        return -1;
    endfunction

    function automatic void clear_entry(int i);
        table_model[i] = '{valid: 1'b0, ifc: '0, port: '0, hi: '0, lo: '0, phase: PH_NONE,
                           lim: '0, sent: '0, deadline: TIME_MAX};
    endfunction

    function automatic rsp_t status_word(logic ok, logic [1:0] st, logic [7:0] done,
                                         logic [4:0] count);
        rsp_t w;
        logic [47:0] best;
        best = TIME_MAX;
        for (int i = 0; i < DEPTH; i++)
            if (table_model[i].valid && table_model[i].deadline < best)
                best = table_model[i].deadline;
        w = '0;
        w.ok = ok;
        w.dad_state = st;
        w.probes_done = done;
        w.probe_count = count;
        if (best < TIME_MAX)
        begin
            w.earliest = best;
            w.dl_valid = 1'b1;
        end
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void predict_request(request_t r);
        logic ok;
        int   k;
        int   cap;
        int   n;
        rsp_t w;
        ok = 1'b0;
        case (r.op)
            OP_ADD:
            begin
                if (r.ifc == 0 || r.port >= port_limit || (r.hi == 0 && r.lo == 0) ||
                    r.hi[63:56] == 8'hFF)
                    ok = 1'b0;
                else if (find_entry(r.ifc, r.hi, r.lo) >= 0)
                    ok = 1'b1;
                else
                begin
                    k = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!table_model[i].valid)
                            k = i;
                    if (k >= 0)
                    begin
                        table_model[k] = '{valid: 1'b1, ifc: r.ifc, port: r.port, hi: r.hi,
                                           lo: r.lo, phase: (r.lim != 0) ? PH_TENT : PH_PREF,
                                           lim: r.lim, sent: '0,
                                           deadline: (r.lim != 0) ?
                                               sat_add(r.now, {16'd0, r.delay}) : TIME_MAX};
                        ok = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                k = find_entry(r.ifc, r.hi, r.lo);
                if (k >= 0)
                begin
                    clear_entry(k);
                    ok = 1'b1;
                end
            end
            OP_REM_IF, OP_REM_PORT:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (table_model[i].valid && ((r.op == OP_REM_IF) ?
                        table_model[i].ifc == r.ifc : table_model[i].port == r.port))
                    begin
                        clear_entry(i);
                        ok = 1'b1;
                    end
            end
            OP_CONFLICT:
            begin
                k = find_entry(r.ifc, r.hi, r.lo);
                if (k >= 0 && table_model[k].phase == PH_TENT)
                begin
                    table_model[k].phase = PH_DUP;
                    table_model[k].deadline = TIME_MAX;
                    ok = 1'b1;
                end
            end
            OP_QUERY:
            begin
                k = find_entry(r.ifc, r.hi, r.lo);
                if (k >= 0)
                begin
                    queue_word(status_word(1'b1, table_model[k].phase,
                                           table_model[k].sent, 5'd0));
                    return;
                end
            end
            OP_POLL:
            begin
                cap = (max_probes > 16) ? 16 : int'(max_probes);
                n = 0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!table_model[i].valid || table_model[i].phase != PH_TENT ||
                        table_model[i].deadline > r.now)
                        continue;
                    if (table_model[i].sent >= table_model[i].lim)
                    begin
                        table_model[i].phase = PH_PREF;
                        table_model[i].deadline = TIME_MAX;
                        continue;
                    end
                    if (n >= cap)
                        break;
                    w = '0;
                    w.kind = 1'b1;
                    w.ok = 1'b1;
                    w.ifc = table_model[i].ifc;
                    w.port = table_model[i].port;
                    w.addr_hi = table_model[i].hi;
                    w.addr_lo = table_model[i].lo;
                    queue_word(w);
                    n++;
                    table_model[i].sent = table_model[i].sent + 8'd1;
                    table_model[i].deadline = sat_add(r.now, {16'd0, retrans_interval});
                end
                queue_word(status_word(1'b1, PH_NONE, 8'd0, n[4:0]));
                return;
            end
            default: ;
        endcase
        queue_word(status_word(ok, PH_NONE, 8'd0, 5'd0));
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h (%0d words pending)",
                 field, got, want, expected_results.size());
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", {63'd0, rsp_ch.last}, 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.kind !== want.kind)
                    report_mismatch("kind", 64'(rsp_ch.kind), 64'(want.kind));
                if (rsp_ch.ok !== want.ok)
                    report_mismatch("ok", 64'(rsp_ch.ok), 64'(want.ok));
                if (rsp_ch.dad_state !== want.dad_state)
                    report_mismatch("dad_state", 64'(rsp_ch.dad_state), 64'(want.dad_state));
                if (rsp_ch.probes_done !== want.probes_done)
                    report_mismatch("probes_done", 64'(rsp_ch.probes_done),
                                    64'(want.probes_done));
                if (rsp_ch.out_ifc_id !== want.ifc)
                    report_mismatch("out_ifc_id", rsp_ch.out_ifc_id, want.ifc);
                if (rsp_ch.out_port !== want.port)
                    report_mismatch("out_port", 64'(rsp_ch.out_port), 64'(want.port));
                if (rsp_ch.out_address_high !== want.addr_hi)
                    report_mismatch("out_address_high", rsp_ch.out_address_high,
                                    want.addr_hi);
                if (rsp_ch.out_address_low !== want.addr_lo)
                    report_mismatch("out_address_low", rsp_ch.out_address_low, want.addr_lo);
                if (rsp_ch.probe_count !== want.probe_count)
                    report_mismatch("probe_count", 64'(rsp_ch.probe_count),
                                    64'(want.probe_count));
                if (rsp_ch.earliest_deadline !== want.earliest)
                    report_mismatch("earliest_deadline", 64'(rsp_ch.earliest_deadline),
                                    64'(want.earliest));
                if (rsp_ch.deadline_valid !== want.dl_valid)
                    report_mismatch("deadline_valid", 64'(rsp_ch.deadline_valid),
                                    64'(want.dl_valid));
                if (rsp_ch.last !== want.last)
                    report_mismatch("last", 64'(rsp_ch.last), 64'(want.last));
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready = 1'b0;
            stall_mode = 1'b0;
            stall_pattern = 13'b1_0110_1110_0101;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                stall_mode = !stall_mode;
            if ($urandom_range(0, 499) == 0)
                stall_pattern = 13'($urandom);
            stall_pattern = {stall_pattern[11:0], stall_pattern[12]};
            rsp_ch.ready = stall_mode ? stall_pattern[0] : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic request_t make_req(op_t op, logic [63:0] ifc, logic [15:0] port,
                                          logic [63:0] hi, logic [63:0] lo, logic [7:0] lim,
                                          logic [31:0] delay, logic [47:0] now);
        request_t r;
        r = '{op: op, ifc: ifc, port: port, hi: hi, lo: lo, lim: lim, delay: delay,
              now: now};
        return r;
    endfunction

    task automatic send_request(request_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            req_ch.valid = 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        burst_left--;
        req_ch.req_type = r.op;
        req_ch.ifc_id = r.ifc;
        req_ch.port_number = r.port;
        req_ch.address_high = r.hi;
        req_ch.address_low = r.lo;
        req_ch.probe_limit = r.lim;
        req_ch.start_delay = r.delay;
        req_ch.now_time = r.now;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(r);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        cfg_ch.index = index;
        cfg_ch.data = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (index)
            CFG_RETRANS:    retrans_interval = value;
            CFG_PORT_LIMIT: port_limit = value[15:0];
            CFG_MAX_PROBES: max_probes = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_config(logic [31:0] retrans, logic [15:0] plimit, logic [4:0] probes);
        wait_idle();
        write_register(CFG_RETRANS, retrans);
        write_register(CFG_PORT_LIMIT, {16'd0, plimit});
        write_register(CFG_MAX_PROBES, {27'd0, probes});
    endtask

    task automatic test_directed();
        logic [63:0] a_hi;
        a_hi = 64'h2001_0db8_0000_0001;
        // add rejects
        send_request(make_req(OP_ADD, 64'd0, 16'd1, a_hi, 64'd1, 8'd2, 32'd10, 48'd0));
        send_request(make_req(OP_ADD, 64'd7, 16'd64, a_hi, 64'd1, 8'd2, 32'd10, 48'd0));
        send_request(make_req(OP_ADD, 64'd7, 16'd1, 64'd0, 64'd0, 8'd2, 32'd10, 48'd0));
        send_request(make_req(OP_ADD, 64'd7, 16'd1, 64'hFF02_0000_0000_0000, 64'd1, 8'd2,
                              32'd10, 48'd0));
        // accepted adds, duplicate add, zero probe limit
        send_request(make_req(OP_ADD, 64'd7, 16'd63, a_hi, 64'd1, 8'd2, 32'd10, 48'd0));
        send_request(make_req(OP_ADD, 64'd7, 16'd63, a_hi, 64'd1, 8'd9, 32'd99, 48'd5));
        send_request(make_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 64'd0, 64'd2, 8'd0,
                              32'd0, 48'd0));
        send_request(make_req(OP_ADD, 64'd8, 16'd3, 64'hFEFF_FFFF_FFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 32'hFFFF_FFFF,
                              TIME_MAX - 48'd5));
        send_request(make_req(OP_QUERY, 64'd7, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, 48'd10));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, 48'd1010));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, 48'd2010));
        send_request(make_req(OP_QUERY, 64'd7, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        // saturated deadline due only at the greatest time
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0,
                              TIME_MAX - 48'd1));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, TIME_MAX));
        send_request(make_req(OP_CONFLICT, 64'd8, 16'd0, 64'hFEFF_FFFF_FFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_CONFLICT, 64'd7, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_QUERY, 64'd8, 16'd0, 64'hFEFF_FFFF_FFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_QUERY, 64'd9, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'd1, 64'd1,
                              8'hFF, 32'hFFFF_FFFF, TIME_MAX));
        send_request(make_req(OP_REMOVE, 64'd7, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_REMOVE, 64'd7, 16'd0, a_hi, 64'd1, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_REM_IF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 64'd0, 64'd0, 8'd0,
                              32'd0, 48'd0));
        send_request(make_req(OP_REM_PORT, 64'd0, 16'd3, 64'd0, 64'd0, 8'd0, 32'd0, 48'd0));
        send_request(make_req(OP_REM_PORT, 64'd0, 16'd3, 64'd0, 64'd0, 8'd0, 32'd0, 48'd0));
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= DEPTH; i++)
            send_request(make_req(OP_ADD, 64'd5, 16'd2, 64'h2001_0000_0000_0000, 64'(i + 1),
                                  8'd1, 32'(i), 48'd100));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, 48'd200));
        send_request(make_req(OP_POLL, 64'd0, 16'd0, 64'd0, 64'd0, 8'd0, 32'd0, 48'd99999));
        send_request(make_req(OP_REM_PORT, 64'd0, 16'd2, 64'd0, 64'd0, 8'd0, 32'd0, 48'd0));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_random(int count, logic [47:0] start_time);
        request_t r;
        int       pick;
        clock_now = start_time;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            clock_now = sat_add(clock_now, 48'($urandom_range(0, 1500)));
            r = make_req(OP_POLL, ifc_pool[$urandom_range(0, 3)],
                         16'($urandom_range(0, port_limit - 1)),
                         hi_pool[$urandom_range(0, 3)], lo_pool[$urandom_range(0, 2)],
                         8'($urandom_range(0, 4)), 32'($urandom_range(0, 3000)), clock_now);
            if ($urandom_range(0, 9) == 0)
                r.lim = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                r.delay = $urandom;
            if ($urandom_range(0, 9) == 0)
                r.port = 16'($urandom);
            if (pick < 35)
                r.op = OP_ADD;
            else if (pick < 60)
                r.op = OP_POLL;
            else if (pick < 72)
                r.op = OP_QUERY;
            else if (pick < 80)
                r.op = OP_CONFLICT;
            else if (pick < 88)
                r.op = OP_REMOVE;
            else if (pick < 92)
                r.op = OP_REM_IF;
            else if (pick < 96)
                r.op = OP_REM_PORT;
            else
                r = make_req(op_t'($urandom_range(0, 7)), rand64(), 16'($urandom), rand64(),
                             rand64(), 8'($urandom), $urandom,
                             48'({$urandom, $urandom} >> 16));
            send_request(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.ifc_id = '0;
        req_ch.port_number = '0;
        req_ch.address_high = '0;
        req_ch.address_low = '0;
        req_ch.probe_limit = '0;
        req_ch.start_delay = '0;
        req_ch.now_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        burst_left = 0;
        retrans_interval = RETRANS_RESET;
        port_limit = PORT_LIMIT_RESET;
        max_probes = MAX_PROBES_RESET;
        for (int i = 0; i < DEPTH; i++)
            clear_entry(i);
        ifc_pool[0] = 64'd1;
        ifc_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        ifc_pool[2] = rand64();
        ifc_pool[3] = rand64() | 64'd1;
        hi_pool[0] = 64'hFE80_0000_0000_0000;
        hi_pool[1] = 64'hFF02_0000_0000_0001;
        hi_pool[2] = rand64() >> 1;
        hi_pool[3] = 64'd0;
        lo_pool[0] = 64'd0;
        lo_pool[1] = rand64();
        lo_pool[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_random(60, 48'd0);
        set_config(32'd1, 16'hFFFF, 5'd1);
        test_random(50, 48'd1000);
        set_config(32'hFFFF_FFFF, 16'd1, 5'd16);
        test_random(40, TIME_MAX - 48'd20000);
        set_config($urandom_range(1, 5000), 16'($urandom_range(2, 200)), 5'd0);
        test_random(40, 48'd0);
        set_config($urandom_range(1, 3000), 16'($urandom_range(2, 100)), 5'd31);
        test_random(50, 48'd5000);
        set_config(RETRANS_RESET, PORT_LIMIT_RESET, 5'($urandom_range(1, 16)));
        test_random(80, {$urandom, 16'd0});

        wait_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
